// ===== hdl/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_pkg: types, constants and helper functions for the RGB to HSV block
// Holds the transaction structs, the fixed channel widths and the arithmetic
// helpers used by the pipeline stages.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // Raw sensor resolution and the scaled channel width.
  localparam int INPUT_BITS = 10;
  localparam int RAW_W      = INPUT_BITS;
  localparam int CHAN_W     = 8;
  localparam int NUM_W      = 2 * CHAN_W;
  localparam int DIV_STEPS  = CHAN_W;

  localparam logic [RAW_W:0]  RAW_FULL   = (RAW_W + 1)'((1 << RAW_W) - 1);
  localparam logic [5:0]      HUE_GAIN   = 6'd43;

  // Hue offsets of the three color sectors.
  localparam logic [CHAN_W-1:0] HUE_BASE_RED   = 8'd0;
  localparam logic [CHAN_W-1:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [CHAN_W-1:0] HUE_BASE_BLUE  = 8'd171;

  typedef struct packed {
    logic [RAW_W-1:0] red_raw;
    logic [RAW_W-1:0] green_raw;
    logic [RAW_W-1:0] blue_raw;
  } rgbhsv_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } rgbhsv_out_t;

  // Data that rides along the divider stages unchanged.
  typedef struct packed {
    logic [CHAN_W-1:0] brightness;
    logic [CHAN_W-1:0] base;
    logic              neg;
    logic              black;
    logic              grey;
  } side_t;

  // One lane of the restoring divider: partial remainder and a shift word
  // that feeds numerator bits out at the top and takes quotient bits in
  // at the bottom.
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [NUM_W-1:0]  sh;
  } div_lane_t;

  // raw * 255 / RAW_FULL, truncated. Dividing by 2^RAW_W first is at most one
  // short, so a single remainder compare fixes the quotient.
  function automatic logic [CHAN_W-1:0] scale_channel(input logic [RAW_W-1:0] raw);
    logic [RAW_W+CHAN_W-1:0] prod;
    logic [CHAN_W-1:0]       q0;
    logic [RAW_W:0]          rem;
    prod = {raw, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, raw};
    q0   = prod[RAW_W+CHAN_W-1:RAW_W];
    rem  = {1'b0, prod[RAW_W-1:0]} + {{(RAW_W + 1 - CHAN_W){1'b0}}, q0};
    if (rem >= RAW_FULL) begin
      return q0 + 1'b1;
    end
    return q0;
  endfunction

  // One quotient bit of a restoring division.
  function automatic div_lane_t div_step(input div_lane_t a, input logic [CHAN_W-1:0] den);
    logic [CHAN_W:0] trial;
    div_lane_t       res;
    trial  = {a.rem, a.sh[NUM_W-1]};
    res.sh = {a.sh[NUM_W-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      res.rem   = CHAN_W'(trial - {1'b0, den});
      res.sh[0] = 1'b1;
    end else begin
      res.rem = trial[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/raw_rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// raw_rgb_to_hsv_converter: raw 10-bit RGB reading to 8-bit HSV
// An accepted start passes through the scaling, max/min, divider and output registers to out_valid.
// Throughput is one transaction per cycle; busy is always low because the
// pipeline never stalls, and the two divisions take one quotient bit per stage.
// Synchronous active-low reset clears the valid bits only; no state is kept.
// ----------------------------------------------------------------------------
module raw_rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rgbhsv_in_t  in_data,
  output logic        out_valid,
  output rgbhsv_out_t out_data
);

  localparam int LATENCY = DIV_STEPS + 4;

  // Stage 1: channel scaling.
  logic              s1_valid_r;
  logic [CHAN_W-1:0] s1_red_r;
  logic [CHAN_W-1:0] s1_green_r;
  logic [CHAN_W-1:0] s1_blue_r;

  // Stage 2: max, min, sector and difference.
  logic              s2_valid_r;
  side_t             s2_side_r;
  logic [CHAN_W-1:0] s2_span_r;
  logic [CHAN_W-1:0] s2_mag_r;

  side_t             s2_side_nxt;
  logic [CHAN_W-1:0] s2_span_nxt;
  logic [CHAN_W-1:0] s2_mag_nxt;

  // Divider pipeline, entry 0 is loaded with the numerators.
  logic              dv_valid_r [DIV_STEPS+1];
  side_t             dv_side_r  [DIV_STEPS+1];
  div_lane_t         sat_r      [DIV_STEPS+1];
  div_lane_t         hue_r      [DIV_STEPS+1];
  logic [CHAN_W-1:0] sat_den_r  [DIV_STEPS+1];
  logic [CHAN_W-1:0] hue_den_r  [DIV_STEPS+1];

  logic [NUM_W-1:0]  sat_num;
  logic [NUM_W-1:0]  hue_num;

  logic              out_valid_r;
  rgbhsv_out_t       out_data_r;
  rgbhsv_out_t       out_data_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
    s1_red_r   <= scale_channel(in_data.red_raw);
    s1_green_r <= scale_channel(in_data.green_raw);
    s1_blue_r  <= scale_channel(in_data.blue_raw);
  end

  always_comb begin
    logic [CHAN_W-1:0] hi;
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W:0]   diff;
    hi = s1_red_r;
    lo = s1_red_r;
    if (s1_green_r > hi) hi = s1_green_r;
    if (s1_blue_r > hi)  hi = s1_blue_r;
    if (s1_green_r < lo) lo = s1_green_r;
    if (s1_blue_r < lo)  lo = s1_blue_r;

    // Red wins ties over green, and green over blue.
    priority if (hi == s1_red_r) begin
      s2_side_nxt.base = HUE_BASE_RED;
      diff = {1'b0, s1_green_r} - {1'b0, s1_blue_r};
    end else if (hi == s1_green_r) begin
      s2_side_nxt.base = HUE_BASE_GREEN;
      diff = {1'b0, s1_blue_r} - {1'b0, s1_red_r};
    end else begin
      s2_side_nxt.base = HUE_BASE_BLUE;
      diff = {1'b0, s1_red_r} - {1'b0, s1_green_r};
    end

    s2_span_nxt            = hi - lo;
    s2_side_nxt.brightness = hi;
    s2_side_nxt.neg        = diff[CHAN_W];
    s2_side_nxt.black      = (hi == '0);
    s2_side_nxt.grey       = (hi == lo);
    s2_mag_nxt             = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_side_r <= s2_side_nxt;
    s2_span_r <= s2_span_nxt;
    s2_mag_r  <= s2_mag_nxt;
  end

  // 255 * span and 43 * |diff|; both quotients fit in CHAN_W bits.
  assign sat_num = {s2_span_r, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, s2_span_r};
  assign hue_num = NUM_W'(s2_mag_r) * NUM_W'(HUE_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else begin
      dv_valid_r[0] <= s2_valid_r;
    end
    dv_side_r[0]  <= s2_side_r;
    sat_r[0].rem  <= sat_num[NUM_W-1:CHAN_W];
    sat_r[0].sh   <= {sat_num[CHAN_W-1:0], {CHAN_W{1'b0}}};
    hue_r[0].rem  <= hue_num[NUM_W-1:CHAN_W];
    hue_r[0].sh   <= {hue_num[CHAN_W-1:0], {CHAN_W{1'b0}}};
    sat_den_r[0]  <= s2_side_r.brightness;
    hue_den_r[0]  <= s2_span_r;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k] <= 1'b0;
      end else begin
        dv_valid_r[k] <= dv_valid_r[k-1];
      end
      dv_side_r[k] <= dv_side_r[k-1];
      sat_r[k]     <= div_step(sat_r[k-1], sat_den_r[k-1]);
      hue_r[k]     <= div_step(hue_r[k-1], hue_den_r[k-1]);
      sat_den_r[k] <= sat_den_r[k-1];
      hue_den_r[k] <= hue_den_r[k-1];
    end
  end

  // Division by zero leaves garbage in the lanes; the black and grey flags
  // mask it here.
  always_comb begin
    logic [CHAN_W-1:0] q_hue;
    q_hue                   = hue_r[DIV_STEPS].sh[CHAN_W-1:0];
    out_data_nxt.brightness = dv_side_r[DIV_STEPS].brightness;
    out_data_nxt.saturation = dv_side_r[DIV_STEPS].black ? '0
                            : sat_r[DIV_STEPS].sh[CHAN_W-1:0];
    if (dv_side_r[DIV_STEPS].grey) begin
      out_data_nxt.hue = '0;
    end else if (dv_side_r[DIV_STEPS].neg) begin
      out_data_nxt.hue = dv_side_r[DIV_STEPS].base - q_hue;
    end else begin
      out_data_nxt.hue = dv_side_r[DIV_STEPS].base + q_hue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid_r[DIV_STEPS];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  ap_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted transaction did not produce a result on time");

  ap_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, LATENCY))
    else $error("result strobe without a matching accepted transaction");

  ap_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.brightness == '0) |->
      (out_data.saturation == '0 && out_data.hue == '0))
    else $error("black input gave nonzero hue or saturation");

  ap_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturation == '0) |-> (out_data.hue == '0))
    else $error("zero saturation with nonzero hue");
`endif

endmodule
